[src/opv_pkg.sv]
// Shared constants and types for the orthogonal pair of vectors unit.
package opv_pkg;

   // Default word width of every vector component (signed fixed point)
   localparam int DEF_WORD_BITS = 32;

   // Sign and special-case flags carried beside the data down the pipeline
   typedef struct packed {
      logic x_neg;
      logic y_neg;
      logic z_neg;
      logic r_neg;
      logic xy_zero;
      logic z_zero;
   } dir_flags_type;

endpackage

[src/opv_delay.sv]
// Shift line that carries a valid bit and side data beside a pipelined unit.
module opv_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = opv_pkg::DEF_WORD_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   output logic [WIDTH-1:0] out_data
);

   logic             valid_ff [DEPTH];
   logic [WIDTH-1:0] data_ff  [DEPTH];

   // valid bits, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < DEPTH; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // payload taps
   always_ff @(posedge clock) begin
      if (en) begin
         data_ff[0] <= in_data;
         for (int i = 1; i < DEPTH; i++) begin
            data_ff[i] <= data_ff[i-1];
         end
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign out_data  = data_ff[DEPTH-1];

endmodule

[src/opv_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
module opv_sqrt #(
   parameter int W = opv_pkg::DEF_WORD_BITS
) (
   input  logic           clock,
   input  logic           en,
   input  logic [2*W-1:0] radicand,
   output logic [W-1:0]   root
);

   localparam int RW = W + 3;

   logic [2*W-1:0] rad_ff  [W];
   logic [RW-1:0]  rem_ff  [W];
   logic [W-1:0]   root_ff [W];

   for (genvar k = 0; k < W; k++) begin : g_stage
      logic [2*W-1:0] rad_src;
      logic [RW-1:0]  rem_src;
      logic [W-1:0]   root_src;
      logic [RW-1:0]  shifted;
      logic [RW-1:0]  trial;

      if (k == 0) begin : g_first
         assign rad_src  = radicand;
         assign rem_src  = '0;
         assign root_src = '0;
      end else begin : g_next
         assign rad_src  = rad_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
      end

      // bring down the next two radicand bits, try root*4+1
      assign shifted = {rem_src[RW-3:0], rad_src[2*W-1 -: 2]};
      assign trial   = {1'b0, root_src, 2'b01};

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k] <= rad_src << 2;
            if (shifted >= trial) begin
               rem_ff[k]  <= shifted - trial;
               root_ff[k] <= {root_src[W-2:0], 1'b1};
            end else begin
               rem_ff[k]  <= shifted;
               root_ff[k] <= {root_src[W-2:0], 1'b0};
            end
         end
      end
   end

   assign root = root_ff[W-1];

endmodule

[src/opv_div.sv]
// Pipelined restoring divider, 2W-bit dividend by W-bit divisor, one quotient bit per stage.
module opv_div #(
   parameter int W = opv_pkg::DEF_WORD_BITS
) (
   input  logic           clock,
   input  logic           en,
   input  logic [2*W-1:0] num,
   input  logic [W-1:0]   den,
   output logic [W-1:0]   quo
);

   // quotient is known to fit W bits, so the high half starts below den
   logic [W-1:0] rem_ff [W];
   logic [W-1:0] low_ff [W];
   logic [W-1:0] quo_ff [W];
   logic [W-1:0] den_ff [W];

   for (genvar k = 0; k < W; k++) begin : g_stage
      logic [W-1:0] rem_src;
      logic [W-1:0] low_src;
      logic [W-1:0] quo_src;
      logic [W-1:0] den_src;
      logic [W:0]   trial;
      logic [W:0]   diff;

      if (k == 0) begin : g_first
         assign rem_src = num[2*W-1:W];
         assign low_src = num[W-1:0];
         assign quo_src = '0;
         assign den_src = den;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign low_src = low_ff[k-1];
         assign quo_src = quo_ff[k-1];
         assign den_src = den_ff[k-1];
      end

      assign trial = {rem_src, low_src[W-1]};
      assign diff  = trial - {1'b0, den_src};

      always_ff @(posedge clock) begin
         if (en) begin
            low_ff[k] <= low_src << 1;
            den_ff[k] <= den_src;
            if (trial >= {1'b0, den_src}) begin
               rem_ff[k] <= diff[W-1:0];
               quo_ff[k] <= {quo_src[W-2:0], 1'b1};
            end else begin
               rem_ff[k] <= trial[W-1:0];
               quo_ff[k] <= {quo_src[W-2:0], 1'b0};
            end
         end
      end
   end

   assign quo = quo_ff[W-1];

endmodule

[src/orthogonal_pair_of_vectors_unit.sv]
// Top level: two vectors perpendicular to a direction and to each other, length |radius|.
//
//  channel  | direction | handshake            | payload
//  req_     | in        | req_valid/req_ready  | dir_x, dir_y, dir_z, radius
//  rsp_     | out       | rsp_valid/rsp_ready  | first_x/y/z, second_x/y/z, degenerate
//
// One transaction per cycle sustained unless an untaken result stalls the pipeline; the depth is
// set by two root pipelines side by side and two banks of divider pipelines, one stage per result bit.
// Synchronous reset clears only valid bits; no clearing pass.
// The pipeline freezes only when the output register holds an untaken result and the
// final stage is full; bubbles are squeezed out while the output waits.
module orthogonal_pair_of_vectors_unit #(
   parameter int WORD_BITS = opv_pkg::DEF_WORD_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [WORD_BITS-1:0] req_dir_x,
   input  logic signed [WORD_BITS-1:0] req_dir_y,
   input  logic signed [WORD_BITS-1:0] req_dir_z,
   input  logic signed [WORD_BITS-1:0] req_radius,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [WORD_BITS-1:0] rsp_first_x,
   output logic signed [WORD_BITS-1:0] rsp_first_y,
   output logic signed [WORD_BITS-1:0] rsp_first_z,
   output logic signed [WORD_BITS-1:0] rsp_second_x,
   output logic signed [WORD_BITS-1:0] rsp_second_y,
   output logic signed [WORD_BITS-1:0] rsp_second_z,
   output logic                        rsp_degenerate
);

   localparam int W  = WORD_BITS;
   localparam int FB = $bits(opv_pkg::dir_flags_type);
   localparam int AB = FB + 5 * W;
   localparam int BB = FB + 4 * W;
   localparam int CB = FB + 5 * W;

   // saturate a signed magnitude to W bits
   function automatic logic [W-1:0] sat(input logic neg, input logic [W-1:0] m);
      logic [W-1:0] r;
      if (neg) begin
         r = m[W-1] ? {1'b1, {(W-1){1'b0}}} : (~m + 1'b1);
      end else begin
         r = m[W-1] ? {1'b0, {(W-1){1'b1}}} : m;
      end
      return r;
   endfunction

   function automatic logic [W-1:0] mag(input logic [W-1:0] v);
      return v[W-1] ? (~v + 1'b1) : v;
   endfunction

   logic advance;
   logic load;
   logic tail_valid;

   // ---------------- stage 1: magnitudes and flags ----------------
   logic                  p1_valid_ff;
   opv_pkg::dir_flags_type p1_flags_ff;
   logic [W-1:0]          p1_xm_ff, p1_ym_ff, p1_zm_ff, p1_rm_ff, p1_rraw_ff;
   opv_pkg::dir_flags_type p1_flags_in;
   logic [W-1:0]          p1_xm_in, p1_ym_in, p1_zm_in, p1_rm_in;

   always_comb begin
      p1_xm_in            = mag(req_dir_x);
      p1_ym_in            = mag(req_dir_y);
      p1_zm_in            = mag(req_dir_z);
      p1_rm_in            = mag(req_radius);
      p1_flags_in.x_neg   = req_dir_x[W-1];
      p1_flags_in.y_neg   = req_dir_y[W-1];
      p1_flags_in.z_neg   = req_dir_z[W-1];
      p1_flags_in.r_neg   = req_radius[W-1];
      p1_flags_in.xy_zero = (req_dir_x == '0) && (req_dir_y == '0);
      p1_flags_in.z_zero  = (req_dir_z == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (advance) begin
         p1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_flags_ff <= p1_flags_in;
         p1_xm_ff    <= p1_xm_in;
         p1_ym_ff    <= p1_ym_in;
         p1_zm_ff    <= p1_zm_in;
         p1_rm_ff    <= p1_rm_in;
         p1_rraw_ff  <= req_radius;
      end
   end

   // ---------------- stage 2: squares ----------------
   logic                  p2_valid_ff;
   opv_pkg::dir_flags_type p2_flags_ff;
   logic [2*W-1:0]        p2_xx_ff, p2_yy_ff, p2_zz_ff;
   logic [W-1:0]          p2_xm_ff, p2_ym_ff, p2_zm_ff, p2_rm_ff, p2_rraw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (advance) begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p2_xx_ff    <= (2*W)'(p1_xm_ff) * (2*W)'(p1_xm_ff);
         p2_yy_ff    <= (2*W)'(p1_ym_ff) * (2*W)'(p1_ym_ff);
         p2_zz_ff    <= (2*W)'(p1_zm_ff) * (2*W)'(p1_zm_ff);
         p2_flags_ff <= p1_flags_ff;
         p2_xm_ff    <= p1_xm_ff;
         p2_ym_ff    <= p1_ym_ff;
         p2_zm_ff    <= p1_zm_ff;
         p2_rm_ff    <= p1_rm_ff;
         p2_rraw_ff  <= p1_rraw_ff;
      end
   end

   // ---------------- stage 3: sums of squares (fit 2W bits) ----------------
   logic                  p3_valid_ff;
   opv_pkg::dir_flags_type p3_flags_ff;
   logic [2*W-1:0]        p3_sxy_ff, p3_sall_ff;
   logic [W-1:0]          p3_xm_ff, p3_ym_ff, p3_zm_ff, p3_rm_ff, p3_rraw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else if (advance) begin
         p3_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p3_sxy_ff   <= p2_xx_ff + p2_yy_ff;
         p3_sall_ff  <= p2_xx_ff + p2_yy_ff + p2_zz_ff;
         p3_flags_ff <= p2_flags_ff;
         p3_xm_ff    <= p2_xm_ff;
         p3_ym_ff    <= p2_ym_ff;
         p3_zm_ff    <= p2_zm_ff;
         p3_rm_ff    <= p2_rm_ff;
         p3_rraw_ff  <= p2_rraw_ff;
      end
   end

   // ---------------- root pipelines: s = |(x,y)|, n = |D| ----------------
   logic [W-1:0]          s_root, n_root;
   logic                  a_valid;
   logic [AB-1:0]         a_data;
   opv_pkg::dir_flags_type a_flags;
   logic [W-1:0]          a_rraw, a_rm, a_xm, a_ym, a_zm;

   opv_sqrt #(.W(W)) u_sqrt_s (
      .clock(clock), .en(advance), .radicand(p3_sxy_ff), .root(s_root)
   );

   opv_sqrt #(.W(W)) u_sqrt_n (
      .clock(clock), .en(advance), .radicand(p3_sall_ff), .root(n_root)
   );

   opv_delay #(.WIDTH(AB), .DEPTH(W)) u_line_a (
      .clock(clock), .reset(reset), .en(advance),
      .in_valid(p3_valid_ff),
      .in_data({p3_flags_ff, p3_rraw_ff, p3_rm_ff, p3_xm_ff, p3_ym_ff, p3_zm_ff}),
      .out_valid(a_valid), .out_data(a_data)
   );

   assign {a_flags, a_rraw, a_rm, a_xm, a_ym, a_zm} = a_data;

   // ---------------- stage 4: numerators r*x, r*y, r*s ----------------
   logic                  p4_valid_ff;
   opv_pkg::dir_flags_type p4_flags_ff;
   logic [2*W-1:0]        p4_rx_ff, p4_ry_ff, p4_rs_ff;
   logic [W-1:0]          p4_s_ff, p4_n_ff, p4_zm_ff, p4_rm_ff, p4_rraw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_valid_ff <= 1'b0;
      end else if (advance) begin
         p4_valid_ff <= a_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p4_rx_ff    <= (2*W)'(a_rm) * (2*W)'(a_xm);
         p4_ry_ff    <= (2*W)'(a_rm) * (2*W)'(a_ym);
         p4_rs_ff    <= (2*W)'(a_rm) * (2*W)'(s_root);
         p4_s_ff     <= s_root;
         p4_n_ff     <= n_root;
         p4_zm_ff    <= a_zm;
         p4_rm_ff    <= a_rm;
         p4_rraw_ff  <= a_rraw;
         p4_flags_ff <= a_flags;
      end
   end

   // ---------------- divider bank A: u, v and the second z ----------------
   logic [W-1:0]          u_quo, v_quo, w_quo;
   logic                  b_valid;
   logic [BB-1:0]         b_data;
   opv_pkg::dir_flags_type b_flags;
   logic [W-1:0]          b_rraw, b_rm, b_zm, b_n;

   opv_div #(.W(W)) u_div_u (
      .clock(clock), .en(advance), .num(p4_rx_ff), .den(p4_s_ff), .quo(u_quo)
   );

   opv_div #(.W(W)) u_div_v (
      .clock(clock), .en(advance), .num(p4_ry_ff), .den(p4_s_ff), .quo(v_quo)
   );

   opv_div #(.W(W)) u_div_w (
      .clock(clock), .en(advance), .num(p4_rs_ff), .den(p4_n_ff), .quo(w_quo)
   );

   opv_delay #(.WIDTH(BB), .DEPTH(W)) u_line_b (
      .clock(clock), .reset(reset), .en(advance),
      .in_valid(p4_valid_ff),
      .in_data({p4_flags_ff, p4_rraw_ff, p4_rm_ff, p4_zm_ff, p4_n_ff}),
      .out_valid(b_valid), .out_data(b_data)
   );

   assign {b_flags, b_rraw, b_rm, b_zm, b_n} = b_data;

   // ---------------- stage 5: numerators u*z, v*z ----------------
   logic                  p5_valid_ff;
   opv_pkg::dir_flags_type p5_flags_ff;
   logic [2*W-1:0]        p5_uz_ff, p5_vz_ff;
   logic [W-1:0]          p5_n_ff, p5_u_ff, p5_v_ff, p5_w_ff, p5_rm_ff, p5_rraw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p5_valid_ff <= 1'b0;
      end else if (advance) begin
         p5_valid_ff <= b_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p5_uz_ff    <= (2*W)'(u_quo) * (2*W)'(b_zm);
         p5_vz_ff    <= (2*W)'(v_quo) * (2*W)'(b_zm);
         p5_n_ff     <= b_n;
         p5_u_ff     <= u_quo;
         p5_v_ff     <= v_quo;
         p5_w_ff     <= w_quo;
         p5_rm_ff    <= b_rm;
         p5_rraw_ff  <= b_rraw;
         p5_flags_ff <= b_flags;
      end
   end

   // ---------------- divider bank B: second x and y ----------------
   logic [W-1:0]          sx_quo, sy_quo;
   logic [CB-1:0]         c_data;
   opv_pkg::dir_flags_type c_flags;
   logic [W-1:0]          c_rraw, c_rm, c_u, c_v, c_w;

   opv_div #(.W(W)) u_div_sx (
      .clock(clock), .en(advance), .num(p5_uz_ff), .den(p5_n_ff), .quo(sx_quo)
   );

   opv_div #(.W(W)) u_div_sy (
      .clock(clock), .en(advance), .num(p5_vz_ff), .den(p5_n_ff), .quo(sy_quo)
   );

   opv_delay #(.WIDTH(CB), .DEPTH(W)) u_line_c (
      .clock(clock), .reset(reset), .en(advance),
      .in_valid(p5_valid_ff),
      .in_data({p5_flags_ff, p5_rraw_ff, p5_rm_ff, p5_u_ff, p5_v_ff, p5_w_ff}),
      .out_valid(tail_valid), .out_data(c_data)
   );

   assign {c_flags, c_rraw, c_rm, c_u, c_v, c_w} = c_data;

   // ---------------- signs, special cases and saturation ----------------
   logic [W-1:0] fx_in, fy_in, sx_in, sy_in, sz_in;
   logic         deg_in;

   always_comb begin
      if (c_flags.xy_zero) begin
         fx_in  = c_rraw;
         fy_in  = '0;
         sx_in  = '0;
         sy_in  = c_flags.z_zero ? '0 : sat(c_flags.z_neg, c_rm);
         sz_in  = '0;
         deg_in = c_flags.z_zero;
      end else begin
         fx_in  = sat(c_flags.y_neg != c_flags.r_neg, c_v);
         fy_in  = sat(c_flags.x_neg == c_flags.r_neg, c_u);
         sx_in  = sat(c_flags.z_neg != c_flags.x_neg, sx_quo);
         sy_in  = sat(c_flags.z_neg != c_flags.y_neg, sy_quo);
         sz_in  = sat(1'b1, c_w);
         deg_in = 1'b0;
      end
   end

   // ---------------- output register and flow control ----------------
   logic         out_valid_ff;
   logic [W-1:0] fx_ff, fy_ff, sx_ff, sy_ff, sz_ff;
   logic         deg_ff;

   assign load      = !out_valid_ff || rsp_ready;
   assign advance   = load || !tail_valid;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load) begin
         out_valid_ff <= tail_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         fx_ff  <= fx_in;
         fy_ff  <= fy_in;
         sx_ff  <= sx_in;
         sy_ff  <= sy_in;
         sz_ff  <= sz_in;
         deg_ff <= deg_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_first_x    = fx_ff;
   assign rsp_first_y    = fy_ff;
   assign rsp_first_z    = '0;
   assign rsp_second_x   = sx_ff;
   assign rsp_second_y   = sy_ff;
   assign rsp_second_z   = sz_ff;
   assign rsp_degenerate = deg_ff;

   // ---------------- assertions ----------------
   // a zero direction leaves the second vector and first y at zero
   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_second_x == '0 && rsp_second_y == '0 && rsp_second_z == '0 &&
         rsp_first_y == '0)
      else $error("degenerate result with nonzero components");

   // second z is minus a magnitude, never positive
   a_second_z_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_second_z[W-1] || rsp_second_z == '0)
      else $error("second z positive");

   // a stalled pipeline always has a full tail and a waiting result
   a_stall_reason: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready && tail_valid)
      else $error("pipeline stalled without a blocked result");

   // a result taken from a full tail is refilled on the next cycle
   a_refill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && tail_valid |=> rsp_valid)
      else $error("result lost from final stage");

endmodule
